@@ design/tpb_pkg.sv @@
// tpb_pkg: shared types and constants of the turtle plotter bitmap block.
// No dependencies; imported by the controller, datapath, top level and checker.
package tpb_pkg;

   // field widths fixed by the interface
   localparam int unsigned CMD_W      = 3;
   localparam int unsigned DIST_W     = 8;
   localparam int unsigned IDX_W      = 5;
   localparam int unsigned BITS_W     = 32;
   localparam int unsigned HEAD_W     = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 5;
   localparam int unsigned MATH_W     = 10;  // signed position +/- distance

   // command codes
   localparam logic [CMD_W-1:0] CMD_PEN_UP   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PEN_DOWN = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RIGHT    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LEFT     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MOVE     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DISPLAY  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_END      = 3'd6;

   // headings
   localparam logic [HEAD_W-1:0] HEAD_NORTH = 2'd0;
   localparam logic [HEAD_W-1:0] HEAD_EAST  = 2'd1;
   localparam logic [HEAD_W-1:0] HEAD_SOUTH = 2'd2;
   localparam logic [HEAD_W-1:0] HEAD_WEST  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_ROW     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COL     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_HEADING = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_PEN     = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_DISP_RD,
      ST_DISP_OUT
   } tpb_state_type;

   // controller -> datapath
   typedef struct packed {
      logic take_item;
      logic rd_row;
      logic wr_row;
      logic step_row;
      logic load_out;
   } tpb_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic start_mark;
      logic start_disp;
      logic at_last;
      logic disp_last;
      logic out_free;
   } tpb_status_type;

endpackage

@@ design/tpb_ram.sv @@
// tpb_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tpb_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tpb_ctrl.sv @@
// tpb_ctrl: sequencer of the turtle plotter; issues row read/write/step commands.
// Depends on tpb_pkg.
module tpb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tpb_pkg::tpb_status_type status,
   output tpb_pkg::tpb_cmd_type    cmd
);
   import tpb_pkg::*;

   tpb_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.start_mark) begin
                  state_in = ST_MARK_RD;
               end else if (status.start_disp) begin
                  state_in = ST_DISP_RD;
               end
            end
         end
         ST_MARK_RD: begin
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            state_in = status.at_last ? ST_IDLE : ST_MARK_RD;
         end
         ST_DISP_RD: begin
            state_in = ST_DISP_OUT;
         end
         ST_DISP_OUT: begin
            if (status.out_free) begin
               state_in = status.disp_last ? ST_IDLE : ST_DISP_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.take_item = req_valid;
         end
         ST_MARK_RD: begin
            cmd.rd_row = 1'b1;
         end
         ST_MARK_WR: begin
            cmd.wr_row   = 1'b1;
            cmd.step_row = !status.at_last;
         end
         ST_DISP_RD: begin
            cmd.rd_row = 1'b1;
         end
         ST_DISP_OUT: begin
            cmd.load_out = status.out_free;
            cmd.step_row = status.out_free && !status.disp_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ design/tpb_datapath.sv @@
// tpb_datapath: turtle state, floor RAM with row valid bits, move setup and
// the result word register. Depends on tpb_pkg and tpb_ram.
module tpb_datapath #(
   parameter int unsigned ROWS = 32,
   parameter int unsigned COLS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tpb_pkg::CMD_W-1:0]        req_command,
   input  logic [tpb_pkg::DIST_W-1:0]       req_distance,
   input  logic                             csr_write_en,
   input  logic [tpb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tpb_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  tpb_pkg::tpb_cmd_type             cmd,
   output tpb_pkg::tpb_status_type          status,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [tpb_pkg::IDX_W-1:0]        rsp_row_index,
   output logic [tpb_pkg::BITS_W-1:0]       rsp_row_bits,
   output logic                             rsp_last_row
);
   import tpb_pkg::*;

   localparam int unsigned RW   = $clog2(ROWS);
   localparam int unsigned CW   = $clog2(COLS);
   localparam int unsigned DISP = (ROWS < BITS_W) ? ROWS : BITS_W;
   localparam int unsigned XW   = (COLS > BITS_W) ? COLS : BITS_W;

   function automatic logic [RW-1:0] sat_row(input logic signed [MATH_W-1:0] v);
      logic [RW-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed(MATH_W'(ROWS - 1))) begin
         res = RW'(ROWS - 1);
      end else begin
         res = RW'(v);
      end
      return res;
   endfunction

   function automatic logic [CW-1:0] sat_col(input logic signed [MATH_W-1:0] v);
      logic [CW-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed(MATH_W'(COLS - 1))) begin
         res = CW'(COLS - 1);
      end else begin
         res = CW'(v);
      end
      return res;
   endfunction

   // turtle state
   logic              pen_ff, pen_in;
   logic [HEAD_W-1:0] heading_ff, heading_in;
   logic [RW-1:0]     pos_row_ff, pos_row_in;
   logic [CW-1:0]     pos_col_ff, pos_col_in;
   logic              halted_ff, halted_in;
   // row walk
   logic [RW-1:0]     cnt_ff, cnt_in;
   logic [RW-1:0]     hi_ff, hi_in;
   logic [COLS-1:0]   mask_ff, mask_in;
   logic [ROWS-1:0]   valid_ff, valid_in;
   logic              row_ok_ff, row_ok_in;
   // result word
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [BITS_W-1:0] rsp_bits_ff, rsp_bits_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [COLS-1:0]   rd_data;
   logic [COLS-1:0]   row_eff;
   logic [XW-1:0]     row_wide;

   logic signed [MATH_W-1:0] r_s, c_s, d_s;
   logic signed [MATH_W-1:0] r_plus, r_minus, c_plus, c_minus;
   logic [CW-1:0]     lo_c, hi_c;
   logic [COLS-1:0]   mask_h;
   logic              is_north, is_south, is_west, is_vert;

   assign r_s     = $signed(MATH_W'(pos_row_ff));
   assign c_s     = $signed(MATH_W'(pos_col_ff));
   assign d_s     = $signed(MATH_W'(req_distance));
   assign r_plus  = r_s + d_s;
   assign r_minus = r_s - d_s;
   assign c_plus  = c_s + d_s;
   assign c_minus = c_s - d_s;

   assign is_north = (heading_ff == HEAD_NORTH);
   assign is_south = (heading_ff == HEAD_SOUTH);
   assign is_west  = (heading_ff == HEAD_WEST);
   assign is_vert  = is_north || is_south;

   // column span of a horizontal stroke, start cell included
   assign lo_c = is_west ? sat_col(c_minus + MATH_W'(1)) : pos_col_ff;
   assign hi_c = is_west ? pos_col_ff : sat_col(c_plus - MATH_W'(1));

   always_comb begin
      for (int i = 0; i < COLS; i++) begin
         mask_h[i] = (i >= int'(lo_c)) && (i <= int'(hi_c));
      end
   end

   // unwritten rows read as blank
   assign row_eff  = row_ok_ff ? rd_data : '0;
   assign row_wide = XW'(row_eff);

   tpb_ram #(
      .WIDTH (COLS),
      .DEPTH (ROWS)
   ) u_tpb_floor (
      .clock   (clock),
      .wr_en   (cmd.wr_row),
      .wr_addr (cnt_ff),
      .wr_data (row_eff | mask_ff),
      .rd_en   (cmd.rd_row),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      pen_in      = pen_ff;
      heading_in  = heading_ff;
      pos_row_in  = pos_row_ff;
      pos_col_in  = pos_col_ff;
      halted_in   = halted_ff;
      cnt_in      = cnt_ff;
      hi_in       = hi_ff;
      mask_in     = mask_ff;
      valid_in    = valid_ff;
      row_ok_in   = row_ok_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_START_ROW: begin
               pos_row_in = (7'(csr_wdata) > 7'(ROWS - 1)) ? RW'(ROWS - 1)
                                                           : RW'(csr_wdata);
            end
            CSR_START_COL: begin
               pos_col_in = (7'(csr_wdata) > 7'(COLS - 1)) ? CW'(COLS - 1)
                                                           : CW'(csr_wdata);
            end
            CSR_START_HEADING: heading_in = csr_wdata[HEAD_W-1:0];
            CSR_START_PEN:     pen_in     = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd.take_item && !halted_ff) begin
         case (req_command)
            CMD_PEN_UP:   pen_in     = 1'b0;
            CMD_PEN_DOWN: pen_in     = 1'b1;
            CMD_RIGHT:    heading_in = heading_ff + HEAD_W'(1);
            CMD_LEFT:     heading_in = heading_ff + HEAD_W'(3);
            CMD_MOVE: begin
               if (is_north) begin
                  pos_row_in = sat_row(r_minus);
               end else if (is_south) begin
                  pos_row_in = sat_row(r_plus);
               end else if (is_west) begin
                  pos_col_in = sat_col(c_minus);
               end else begin
                  pos_col_in = sat_col(c_plus);
               end
               if (is_vert) begin
                  // one cell per row, walk rows lo..hi
                  cnt_in  = is_north ? sat_row(r_minus + MATH_W'(1)) : pos_row_ff;
                  hi_in   = is_north ? pos_row_ff : sat_row(r_plus - MATH_W'(1));
                  mask_in = COLS'(1) << pos_col_ff;
               end else begin
                  cnt_in  = pos_row_ff;
                  hi_in   = pos_row_ff;
                  mask_in = mask_h;
               end
            end
            CMD_DISPLAY: cnt_in    = '0;
            CMD_END:     halted_in = 1'b1;
            default: ;
         endcase
      end

      if (cmd.rd_row) begin
         row_ok_in = valid_ff[cnt_ff];
      end
      if (cmd.wr_row) begin
         valid_in[cnt_ff] = 1'b1;
      end
      if (cmd.step_row) begin
         cnt_in = cnt_ff + RW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = IDX_W'(cnt_ff);
         rsp_bits_in  = row_wide[BITS_W-1:0];
         rsp_last_in  = (cnt_ff == RW'(DISP - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff       <= 1'b0;
         heading_ff   <= HEAD_EAST;
         pos_row_ff   <= '0;
         pos_col_ff   <= '0;
         halted_ff    <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pen_ff       <= pen_in;
         heading_ff   <= heading_in;
         pos_row_ff   <= pos_row_in;
         pos_col_ff   <= pos_col_in;
         halted_ff    <= halted_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      hi_ff       <= hi_in;
      mask_ff     <= mask_in;
      row_ok_ff   <= row_ok_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.start_mark = !halted_ff && (req_command == CMD_MOVE) && pen_ff
                              && (req_distance != '0);
   assign status.start_disp = !halted_ff && (req_command == CMD_DISPLAY);
   assign status.at_last    = (cnt_ff == hi_ff);
   assign status.disp_last  = (cnt_ff == RW'(DISP - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_idx_ff;
   assign rsp_row_bits  = rsp_bits_ff;
   assign rsp_last_row  = rsp_last_ff;

endmodule

@@ design/turtle_plotter_bitmap.sv @@
// turtle_plotter_bitmap: top level of the turtle command interpreter.
// Depends on tpb_pkg, tpb_ctrl, tpb_datapath (and tpb_ram below it).
//
// Usage:
//   req_*  : one command word per handshake (command, distance).
//   rsp_*  : display dump, one word per floor row (index, bits, last flag);
//            rows 0 .. min(ROWS,32)-1 in order, last_row set on the final one.
//   csr_*  : plain write port; a write loads the position, heading or pen
//            state at once. Write only while the block is idle.
// Sequencing:
//   pen up/down, turns, end, unused code, zero-length or pen-up move: taken
//   in the idle state, which stays idle. Drawing move: accepted, then a read
//   state and a write state per touched row (read, then write of one floor
//   row through the RAM's registered read port); one row horizontally, up to
//   ROWS rows vertically. Display: accepted, then a read state and an output
//   state per row; the output state waits while the result register is full.
// Reset: turtle at row 0, column 0, heading east, pen up, not halted; every
//   floor row's valid bit is cleared so the floor reads blank, no clearing pass.
// Stall: the result word sits in an output register; a stalled receiver
//   holds the dump, and a new command is taken as soon as the last row is
//   loaded, even if that row has not yet been taken.
// After an end command every word is accepted and dropped until reset.
module turtle_plotter_bitmap #(
   parameter int unsigned ROWS = 32,
   parameter int unsigned COLS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // command channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tpb_pkg::CMD_W-1:0]      req_command,
   input  logic [tpb_pkg::DIST_W-1:0]     req_distance,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tpb_pkg::IDX_W-1:0]      rsp_row_index,
   output logic [tpb_pkg::BITS_W-1:0]     rsp_row_bits,
   output logic                           rsp_last_row,
   // configuration
   input  logic                           csr_write_en,
   input  logic [tpb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tpb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tpb_pkg::*;

   tpb_cmd_type    cmd;
   tpb_status_type status;

   // sequencer: idle / row read-modify-write walk / display walk
   tpb_ctrl u_tpb_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // state, floor memory and result word register
   tpb_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_tpb_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_command   (req_command),
      .req_distance  (req_distance),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_row_index (rsp_row_index),
      .rsp_row_bits  (rsp_row_bits),
      .rsp_last_row  (rsp_last_row)
   );

endmodule

@@ design/tpb_checker.sv @@
// tpb_checker: port-level assertions for turtle_plotter_bitmap, bound to the top.
// Depends on tpb_pkg.
module tpb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [tpb_pkg::IDX_W-1:0]      rsp_row_index,
   input logic [tpb_pkg::BITS_W-1:0]     rsp_row_bits,
   input logic                           rsp_last_row
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_index)
         && $stable(rsp_row_bits) && $stable(rsp_last_row))
      else $error("result word changed while stalled");

   // mid-dump the command channel is closed
   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_row |-> !req_ready)
      else $error("command taken in the middle of a display dump");

   // first row of a dump needs a RAM read first
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result word appeared one cycle after a command");

   // reset empties the result register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind turtle_plotter_bitmap tpb_checker u_tpb_checker (.*);
